// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCMI_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define SCMI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// File: src/scmi_pkg.sv
// ----------------------------------------------------------------------------
// scmi_pkg
// Types and constants of the sorted colour map interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package scmi_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [15:0] height;
        logic [23:0]        color;
    } entry_t;

endpackage

`default_nettype wire

// File: src/scmi_ram.sv
// ----------------------------------------------------------------------------
// scmi_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scmi_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: src/sorted_colormap_interpolator.sv
// ----------------------------------------------------------------------------
// sorted_colormap_interpolator
// Sorted table of (height, colour) entries mapping heights to colours.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready) carries an operation: clear, insert or
// look up. Every input transaction yields exactly one result transaction on
// the m_valid/m_ready channel, with the colour channels and a status code.
// One transaction is handled at a time: s_ready is high only while the
// sequencer is idle, which is from the cycle after the result is loaded.
// A clear, an unused operation or a rejected request goes straight to the
// result stage. An insert walks the table downwards, one entry per cycle
// through the RAM read port, shifting larger entries up; into an empty
// table it writes the new entry without a walk.
// A lookup reads the first and last entries and clamps to them, else scans
// upwards one entry per cycle; an exact match is taken as it is, and a height
// between two entries runs each colour channel through one shared multiplier
// and an 8-step shift-subtract divider.
// Reset empties the table at once; entry contents are not cleared. A finished
// result waits in the output register while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_colormap_interpolator #(
    parameter int TABLE_DEPTH = scmi_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_op,
    input  wire logic signed [15:0] s_height,
    input  wire logic [23:0]        s_entry_color,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_red,
    output logic [7:0]              m_green,
    output logic [7:0]              m_blue,
    output logic [1:0]              m_status
);

    import scmi_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_INS_WAIT = 11'b000_0000_0010,
        S_INS_SCAN = 11'b000_0000_0100,
        S_INS_PUT  = 11'b000_0000_1000,
        S_LK_WAIT  = 11'b000_0001_0000,
        S_LK_FIRST = 11'b000_0010_0000,
        S_LK_LAST  = 11'b000_0100_0000,
        S_LK_SCAN  = 11'b000_1000_0000,
        S_MUL      = 11'b001_0000_0000,
        S_DIV      = 11'b010_0000_0000,
        S_RESP     = 11'b100_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      addr_reg, addr_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      pos_reg, pos_next;
    logic signed [15:0] h_reg, h_next;
    logic [23:0]        new_color_reg, new_color_next;
    entry_t             prev_reg, prev_next;
    logic [23:0]        nxt_color_reg, nxt_color_next;
    logic [15:0]        den_reg, den_next;
    logic [15:0]        num_reg, num_next;
    logic [1:0]         ch_reg, ch_next;
    logic [23:0]        rem_reg, rem_next;
    logic [7:0]         q_reg, q_next;
    logic [2:0]         bit_reg, bit_next;
    logic               neg_reg, neg_next;
    logic [7:0]         base_reg, base_next;
    logic [23:0]        res_color_reg, res_color_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [23:0]        m_color_reg, m_color_next;
    logic [1:0]         m_status_reg, m_status_next;

    logic               ram_wr_en;
    logic [IW-1:0]      ram_wr_addr;
    entry_t             ram_wr_data;
    entry_t             rd_entry;

    logic [7:0]         chan_a, chan_b, mag;
    logic [23:0]        trial;
    logic [7:0]         q_step;
    logic [7:0]         q_fin;
    logic [7:0]         chan_res;

    function automatic logic [7:0] pick_chan(input logic [23:0] c, input logic [1:0] ch);
        logic [7:0] r;
        case (ch)
            2'd0:    r = c[23:16];
            2'd1:    r = c[15:8];
            default: r = c[7:0];
        endcase
        return r;
    endfunction

    scmi_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (addr_reg),
        .rd_data (rd_entry)
    );

    // Shared datapath: channel difference, multiplier and one divider step.
    assign chan_a   = pick_chan(prev_reg.color, ch_reg);
    assign chan_b   = pick_chan(nxt_color_reg, ch_reg);
    assign mag      = (chan_b < chan_a) ? (chan_a - chan_b) : (chan_b - chan_a);
    assign trial    = {8'b0, den_reg} << bit_reg;
    assign q_step   = q_reg | (8'd1 << bit_reg);
    assign q_fin    = (rem_reg >= trial) ? q_step : q_reg;
    assign chan_res = neg_reg ? (base_reg - q_fin) : (base_reg + q_fin);

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_red    = m_color_reg[23:16];
    assign m_green  = m_color_reg[15:8];
    assign m_blue   = m_color_reg[7:0];
    assign m_status = m_status_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        h_next          = h_reg;
        new_color_next  = new_color_reg;
        prev_next       = prev_reg;
        nxt_color_next  = nxt_color_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        ch_next         = ch_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        bit_next        = bit_reg;
        neg_next        = neg_reg;
        base_next       = base_reg;
        res_color_next  = res_color_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_color_next    = m_color_reg;
        m_status_next   = m_status_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = pos_reg;
        ram_wr_data     = '{height: h_reg, color: new_color_reg};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    h_next          = s_height;
                    new_color_next  = s_entry_color;
                    res_color_next  = '0;
                    res_status_next = ST_OK;
                    state_next      = S_RESP;
                    case (s_op)
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_INSERT: begin
                            if (count_reg == CW'(TABLE_DEPTH)) begin
                                res_status_next = ST_FULL;
                            end else if (count_reg == '0) begin
                                pos_next   = '0;
                                state_next = S_INS_PUT;
                            end else begin
                                addr_next  = IW'(count_reg - CW'(1));
                                idx_next   = IW'(count_reg - CW'(1));
                                state_next = S_INS_WAIT;
                            end
                        end
                        OP_LOOKUP: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                addr_next  = '0;
                                state_next = S_LK_WAIT;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_INS_WAIT: begin
                addr_next  = addr_reg - IW'(1);
                state_next = S_INS_SCAN;
            end

            // Walk downwards; every entry above the new height moves up one slot.
            S_INS_SCAN: begin
                if (rd_entry.height > h_reg) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = idx_reg + IW'(1);
                    ram_wr_data = rd_entry;
                    if (idx_reg == '0) begin
                        pos_next   = '0;
                        state_next = S_INS_PUT;
                    end else begin
                        idx_next  = idx_reg - IW'(1);
                        addr_next = addr_reg - IW'(1);
                    end
                end else begin
                    pos_next   = idx_reg + IW'(1);
                    state_next = S_INS_PUT;
                end
            end

            S_INS_PUT: begin
                ram_wr_en  = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end

            S_LK_WAIT: begin
                addr_next  = IW'(count_reg - CW'(1));
                state_next = S_LK_FIRST;
            end

            S_LK_FIRST: begin
                prev_next  = rd_entry;
                addr_next  = IW'(1);
                state_next = S_LK_LAST;
            end

            // Clamp at or below the first entry and at or above the last, else scan from entry one.
            S_LK_LAST: begin
                if (h_reg <= prev_reg.height) begin
                    res_color_next = prev_reg.color;
                    state_next     = S_RESP;
                end else if (h_reg >= rd_entry.height) begin
                    res_color_next = rd_entry.color;
                    state_next     = S_RESP;
                end else begin
                    addr_next  = addr_reg + IW'(1);
                    state_next = S_LK_SCAN;
                end
            end

            S_LK_SCAN: begin
                if (rd_entry.height == h_reg) begin
                    res_color_next = rd_entry.color;
                    state_next     = S_RESP;
                end else if (rd_entry.height > h_reg) begin
                    nxt_color_next = rd_entry.color;
                    den_next       = rd_entry.height - prev_reg.height;
                    num_next       = h_reg - prev_reg.height;
                    ch_next        = '0;
                    state_next     = S_MUL;
                end else begin
                    prev_next = rd_entry;
                    addr_next = addr_reg + IW'(1);
                end
            end

            S_MUL: begin
                rem_next   = {16'b0, mag} * {8'b0, num_reg};
                neg_next   = chan_b < chan_a;
                base_next  = chan_a;
                q_next     = '0;
                bit_next   = 3'd7;
                state_next = S_DIV;
            end

            // The quotient never exceeds the channel difference, so eight steps suffice.
            S_DIV: begin
                if (rem_reg >= trial) begin
                    rem_next = rem_reg - trial;
                    q_next   = q_step;
                end
                bit_next = bit_reg - 3'd1;
                if (bit_reg == 3'd0) begin
                    case (ch_reg)
                        2'd0:    res_color_next[23:16] = chan_res;
                        2'd1:    res_color_next[15:8]  = chan_res;
                        default: res_color_next[7:0]   = chan_res;
                    endcase
                    if (ch_reg == 2'd2) begin
                        state_next = S_RESP;
                    end else begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end

            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_color_next  = res_color_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        h_reg          <= h_next;
        new_color_reg  <= new_color_next;
        prev_reg       <= prev_next;
        nxt_color_reg  <= nxt_color_next;
        den_reg        <= den_next;
        num_reg        <= num_next;
        ch_reg         <= ch_next;
        rem_reg        <= rem_next;
        q_reg          <= q_next;
        bit_reg        <= bit_next;
        neg_reg        <= neg_next;
        base_reg       <= base_next;
        res_color_reg  <= res_color_next;
        res_status_reg <= res_status_next;
        m_color_reg    <= m_color_next;
        m_status_reg   <= m_status_next;
    end

endmodule

`default_nettype wire

// File: src/scmi_checker.sv
// ----------------------------------------------------------------------------
// scmi_checker
// Port-level assertions for the sorted colour map interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module scmi_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_red,
    input wire logic [7:0] m_green,
    input wire logic [7:0] m_blue,
    input wire logic [1:0] m_status
);

    import scmi_pkg::*;

    logic [1:0]  pending_reg;
    logic        is_error;
    logic [25:0] m_result;

    assign is_error = (m_status == ST_FULL) || (m_status == ST_EMPTY);
    assign m_result = {m_red, m_green, m_blue, m_status};

    // Counts accepted transactions whose results have not yet been taken. A new
    // request may be accepted while the previous result still waits, so two
    // can be outstanding.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 2'(s_valid && s_ready) - 2'(m_valid && m_ready);
        end
    end

    `SCMI_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    `SCMI_ASSERT_IMPLY(a_result_has_request, aclk, aresetn, m_valid, pending_reg != 2'd0)

    `SCMI_ASSERT_IMPLY(a_error_is_black, aclk, aresetn, m_valid && is_error, m_result[25:2] == 24'd0)

    `SCMI_ASSERT_NEXT(a_stalled_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result))

endmodule

bind sorted_colormap_interpolator scmi_checker u_scmi_checker (.*);

`default_nettype wire

// File: dv/tb_sorted_colormap_interpolator.sv
// ----------------------------------------------------------------------------
// tb_sorted_colormap_interpolator
// Self-checking bench for the sorted colour map interpolator. A queue of
// clear, insert and lookup commands feeds a valid/ready driver that pauses at
// random. A monitor predicts each accepted command against a shadow of the
// sorted table and checks every result transaction field by field, while the
// receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_sorted_colormap_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    import scmi_pkg::*;

    localparam int DEPTH      = DEF_TABLE_DEPTH;
    localparam int N_RANDOM   = 1500;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN      = 100;

    typedef struct {
        logic [1:0]         op;
        logic signed [15:0] height;
        logic [23:0]        colour;
    } map_cmd_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] status;
    } map_result_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [1:0]         s_op          = OP_CLEAR;
    logic signed [15:0] s_height      = '0;
    logic [23:0]        s_entry_color = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [7:0]         m_red;
    logic [7:0]         m_green;
    logic [7:0]         m_blue;
    logic [1:0]         m_status;

    sorted_colormap_interpolator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_height      (s_height),
        .s_entry_color (s_entry_color),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_status      (m_status)
    );

    always #5ns aclk = ~aclk;

    map_cmd_t    cmd_backlog[$];
    map_result_t colour_due[$];

    // Shadow of the sorted table, updated as commands are accepted.
    int          map_height[DEPTH];
    logic [23:0] map_colour[DEPTH];
    int          map_count = 0;

    // Heights the generator has planned into the table, for exact-match probes.
    int          plan_h[$];

    int n_issued    = 0;
    int n_taken     = 0;
    int n_returned  = 0;
    int n_seen      = 0;
    int fail_count  = 0;
    int idle_cycles = 0;
    int in_wait     = 0;
    int out_wait    = 0;

    function automatic logic [7:0] blend_channel(int a, int b, int num, int den);
        int q;
        // Signed integer division truncates toward zero.
        q = ((b - a) * num) / den;
        return 8'(a + q);
    endfunction

    function automatic logic [23:0] colour_for_height(int h);
        int          prev;
        int          num;
        int          den;
        int          i;
        logic [23:0] pc;
        logic [23:0] nc;
        prev = 0;
        if (h <= map_height[0]) return map_colour[0];
        if (h >= map_height[map_count - 1]) return map_colour[map_count - 1];
        for (i = 0; i < map_count; i++) begin
            if (h == map_height[i]) return map_colour[i];
            if (h > map_height[i]) begin
                prev = i;
            end else begin
                den = map_height[i] - map_height[prev];
                num = h - map_height[prev];
                pc  = map_colour[prev];
                nc  = map_colour[i];
                return {blend_channel(pc[23:16], nc[23:16], num, den),
                        blend_channel(pc[15:8], nc[15:8], num, den),
                        blend_channel(pc[7:0], nc[7:0], num, den)};
            end
        end
        return '0;
    endfunction

    function automatic map_result_t apply_command(map_cmd_t c);
        map_result_t r;
        int          pos;
        int          j;
        r = '0;
        case (c.op)
            OP_CLEAR: begin
                map_count = 0;
            end
            OP_INSERT: begin
                if (map_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // New entries go after every entry of equal height.
                    pos = 0;
                    while (pos < map_count && map_height[pos] <= c.height) pos++;
                    for (j = map_count; j > pos; j--) begin
                        map_height[j] = map_height[j - 1];
                        map_colour[j] = map_colour[j - 1];
                    end
                    map_height[pos] = c.height;
                    map_colour[pos] = c.colour;
                    map_count++;
                end
            end
            OP_LOOKUP: begin
                if (map_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    {r.red, r.green, r.blue} = colour_for_height(c.height);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int draw_wait(int n);
        // Every fourth stretch of a hundred transactions runs without idling.
        if ((n / 100) % 4 == 3) return 0;
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic int rand_height();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic logic [23:0] rand_colour();
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    function automatic int pick_probe(int lo, int span);
        int h;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                if (plan_h.size() == 0) return lo;
                return plan_h[$urandom_range(0, plan_h.size() - 1)];
            end
            3:       return ($urandom_range(0, 1) != 0) ? -32768 : 32767;
            4:       return rand_height();
            default: begin
                h = lo - 4 + int'($urandom_range(0, span + 8));
                if (h < -32768) h = -32768;
                if (h > 32767) h = 32767;
                return h;
            end
        endcase
    endfunction

    task automatic queue_cmd(logic [1:0] op, int h, logic [23:0] col);
        map_cmd_t c;
        c.op     = op;
        c.height = h[15:0];
        c.colour = col;
        cmd_backlog = {cmd_backlog, c};
        if (op == OP_CLEAR) begin
            plan_h.delete();
        end else if (op == OP_INSERT && plan_h.size() < DEPTH) begin
            plan_h = {plan_h, h};
        end
    endtask

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Driver: presents commands and paces the receiver at the falling edge.
    always @(negedge aclk) begin
        map_cmd_t head;
        if (aresetn) begin
            if (!(s_valid && n_taken != n_issued)) begin
                if (s_valid) in_wait = draw_wait(n_taken);
                if (in_wait > 0) begin
                    in_wait--;
                    s_valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    head = cmd_backlog.pop_front();
                    s_op          <= head.op;
                    s_height      <= head.height;
                    s_entry_color <= head.colour;
                    s_valid       <= 1'b1;
                    n_issued++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (n_returned != n_seen) begin
                n_seen   = n_returned;
                out_wait = draw_wait(n_returned);
            end
            if (out_wait > 0) begin
                out_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts accepted commands and checks result transactions.
    always @(posedge aclk) begin
        map_cmd_t    got;
        map_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                got.op     = s_op;
                got.height = s_height;
                got.colour = s_entry_color;
                colour_due = {colour_due, apply_command(got)};
                n_taken++;
            end
            if (m_valid && m_ready) begin
                n_returned++;
                if (colour_due.size() == 0) begin
                    $error("result transaction with no command outstanding");
                    fail_count++;
                end else begin
                    want = colour_due.pop_front();
                    compare_field("red", want.red, m_red);
                    compare_field("green", want.green, m_green);
                    compare_field("blue", want.blue, m_blue);
                    compare_field("status", want.status, m_status);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $error("no transaction for %0d cycles", IDLE_LIMIT);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    initial begin
        int total;
        int k;
        int n_ins;
        int span;
        int lo;

        // Directed opening: empty table, extreme heights and colours,
        // equal heights, then a full table and a dropped insert.
        queue_cmd(OP_LOOKUP, -32768, 24'h000000);
        queue_cmd(OP_CLEAR, 32767, 24'hFFFFFF);
        queue_cmd(OP_INSERT, -32768, 24'h000000);
        queue_cmd(OP_INSERT, 32767, 24'hFFFFFF);
        queue_cmd(OP_LOOKUP, -32768, 24'h000000);
        queue_cmd(OP_LOOKUP, 32767, 24'h000000);
        queue_cmd(OP_LOOKUP, 0, 24'h000000);
        queue_cmd(OP_INSERT, 0, 24'h123456);
        queue_cmd(OP_INSERT, 0, 24'hABCDEF);
        queue_cmd(OP_LOOKUP, 0, 24'h000000);
        queue_cmd(OP_LOOKUP, 1, 24'h000000);
        queue_cmd(OP_LOOKUP, -1, 24'h000000);
        for (k = 0; k < DEPTH - 4; k++) begin
            queue_cmd(OP_INSERT, (k % 4) * 5000 - 9000, rand_colour());
        end
        queue_cmd(OP_INSERT, 100, 24'h5A5A5A);
        queue_cmd(OP_LOOKUP, 2500, 24'h000000);

        // Mostly well-formed sessions: clear, a run of inserts in a chosen
        // height window, then probes in and around that window.
        total = cmd_backlog.size() + N_RANDOM;
        while (cmd_backlog.size() < total) begin
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 7) != 0) begin
                    queue_cmd(OP_CLEAR, rand_height(), rand_colour());
                end
                n_ins = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 18)
                                                    : $urandom_range(1, 8);
                case ($urandom_range(0, 2))
                    0:       span = $urandom_range(0, 63);
                    1:       span = $urandom_range(64, 4000);
                    default: span = 65535;
                endcase
                lo = int'($urandom_range(0, 65535 - span)) - 32768;
                repeat (n_ins) begin
                    queue_cmd(OP_INSERT, lo + int'($urandom_range(0, span)), rand_colour());
                end
                repeat ($urandom_range(1, 10)) begin
                    queue_cmd(OP_LOOKUP, pick_probe(lo, span), rand_colour());
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    queue_cmd(2'($urandom_range(0, 2)), rand_height(), rand_colour());
                end
            end
        end
        total = cmd_backlog.size();

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk); while (n_taken != total || colour_due.size() != 0);
        repeat (DRAIN) @(negedge aclk);

        if (colour_due.size() != 0) begin
            $error("%0d results never arrived", colour_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
